// ===== sv/kfrp_pkg.sv =====
`timescale 1ns / 1ps

package kfrp_pkg;

  localparam int LINES_PER_CHAR = 32;
  localparam int LINE_W = $clog2(LINES_PER_CHAR);
  localparam int NUM_W = 12;
  localparam int FIELD_W = 6;
  localparam int DIVIDEND_W = 13;
  localparam int QUOT_W = 6;
  localparam int REM_W = 7;
  localparam int IDX_W = 13;
  localparam int ADDR_W = 17;
  localparam int WORD_SHIFT = 4;

  localparam int CHARS_PER_ROW = 96;
  localparam int CHARS_PER_KU = 94;
  localparam int WORDS_PER_CHAR = 16;

  localparam logic [NUM_W-1:0] SYM_LIMIT = NUM_W'(16 * 96 - 512);
  localparam logic [DIVIDEND_W-1:0] KANJI_BIAS = DIVIDEND_W'(512);

  // Base word offset minus the (ku * 94 + ten) bias of each area, modulo 2^17.
  localparam logic [ADDR_W-1:0] FIRST_SYM_ADJ =
    ADDR_W'(0 - (CHARS_PER_KU * 1 + 1) * WORDS_PER_CHAR);
  localparam logic [ADDR_W-1:0] FIRST_KANJI_ADJ =
    ADDR_W'(32'h2F00 - (CHARS_PER_KU * 16 + 1) * WORDS_PER_CHAR);
  localparam logic [ADDR_W-1:0] SECOND_ADJ =
    ADDR_W'(32'hEB00 - WORDS_PER_CHAR);

  localparam logic [NUM_W-1:0] FIRST_CHECK_NUM = NUM_W'(1 * 96 + 32);
  localparam logic [NUM_W-1:0] SECOND_CHECK_NUM = NUM_W'(35 * 96 + 94);

  localparam logic [7:0] FIRST_CHECK [8] = '{
    8'h00, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
  };
  localparam logic [7:0] SECOND_CHECK [8] = '{
    8'h01, 8'h02, 8'h0c, 8'h37, 8'hc0, 8'h3b, 8'h2a, 8'h2a
  };

  localparam logic [7:0] DUMMY_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    CMD_WR_LO = 2'd0,
    CMD_WR_HI = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DUMMY = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic [ADDR_W-1:0] fetch_addr_first;
    logic [ADDR_W-1:0] fetch_addr_second;
  } rsp_t;

endpackage

// ===== sv/kfrp_if.sv =====
`timescale 1ns / 1ps

interface kfrp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        level;
  logic [7:0]  data;
  logic [15:0] font_word;

  modport source (output valid, output cmd, output level, output data,
                  output font_word, input ready);
  modport sink (input valid, input cmd, input level, input data,
                input font_word, output ready);
endinterface

interface kfrp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [16:0] fetch_addr_first;
  logic [16:0] fetch_addr_second;

  modport source (output valid, output read_data, output fetch_addr_first,
                  output fetch_addr_second, input ready);
  modport sink (input valid, input read_data, input fetch_addr_first,
                input fetch_addr_second, output ready);
endinterface

// ===== sv/kfrp_divmod96.sv =====
`timescale 1ns / 1ps

module kfrp_divmod96
  import kfrp_pkg::*;
(
  input  logic [DIVIDEND_W-1:0] value,
  output logic [QUOT_W-1:0]     quot,
  output logic [REM_W-1:0]      rem
);

  logic [7:0]            hi;
  logic [15:0]           prod;
  logic [DIVIDEND_W-1:0] back;

  // Divide by 32 with a shift, then by 3 through multiplication by 171/512.
  assign hi   = value[DIVIDEND_W-1:5];
  assign prod = 16'(hi) * 16'd171;
  assign quot = prod[9+QUOT_W-1:9];
  assign back = DIVIDEND_W'(quot) * DIVIDEND_W'(CHARS_PER_ROW);
  assign rem  = REM_W'(value - back);

endmodule

// ===== sv/kfrp_skid.sv =====
`timescale 1ns / 1ps

module kfrp_skid
  import kfrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rsp_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  logic spare_valid;
  rsp_t spare;

  assign in_ready = !spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= spare_valid ? spare : in_data;
    end else if (in_valid && in_ready) begin
      spare <= in_data;
    end
  end

  a_spare_implies_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("Skid entry held while output register is empty.");

  a_stall_to_spare: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_valid && !out_ready) |=> spare_valid)
    else $error("Transaction accepted during a stall was not kept.");

  a_spare_drains: assert property (@(posedge clk) disable iff (rst)
    (spare_valid && out_ready) |=> (out_valid && !spare_valid))
    else $error("Skid entry did not move to the output register.");

endmodule

// ===== sv/kanji_font_rom_port_unit.sv =====
`timescale 1ns / 1ps

// Kanji font ROM port for a first-level and a second-level ROM. Each request
// transaction is a number write (low or high six bits, which also rewinds the
// line counter), a pattern read or a dummy read, and gives exactly one response
// transaction carrying the read byte and the font-store word addresses that the
// next read of each level needs; font_word on a read must be the word at the
// address from the previous response of that level. All decoding, the divide
// by 96 and the address arithmetic sit between the request and the response
// register, so while the response side is ready the block takes one request
// per cycle and the response appears in the cycle after acceptance. When a
// response waits, a two-entry output buffer accepts one more request and then
// holds off the request side. The request side also pauses in the cycle in
// which the buffered response moves up to the output.
module kanji_font_rom_port_unit
  import kfrp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  kfrp_req_if.sink  req,
  kfrp_rsp_if.source rsp
);

  logic [NUM_W-1:0]  first_num, first_num_next;
  logic [NUM_W-1:0]  second_num, second_num_next;
  logic [LINE_W-1:0] first_line, first_line_next;
  logic [LINE_W-1:0] second_line, second_line_next;

  logic              accept;
  logic              buf_ready;
  logic [LINE_W-1:0] cur_line;
  logic              check_hit;
  logic [7:0]        high_byte;
  logic [7:0]        read_byte;

  logic                  first_sym;
  logic [DIVIDEND_W-1:0] first_dividend;
  logic [QUOT_W-1:0]     first_quot, second_quot;
  logic [REM_W-1:0]      first_rem, second_rem;
  logic [IDX_W-1:0]      first_idx, second_idx;
  logic [3:0]            first_off, second_off;
  rsp_t                  result;
  rsp_t                  rsp_data;

  assign accept    = req.valid && buf_ready;
  assign req.ready = buf_ready;

  assign cur_line  = req.level ? second_line : first_line;
  assign check_hit = (cur_line < LINE_W'(8)) &&
                     (req.level ? (second_num == SECOND_CHECK_NUM)
                                : (first_num == FIRST_CHECK_NUM));
  assign high_byte = !check_hit ? req.font_word[15:8] :
                     req.level ? SECOND_CHECK[cur_line[2:0]] :
                                 FIRST_CHECK[cur_line[2:0]];

  always_comb begin
    first_num_next   = first_num;
    second_num_next  = second_num;
    first_line_next  = first_line;
    second_line_next = second_line;
    read_byte        = 8'h00;
    if (accept) begin
      unique case (cmd_t'(req.cmd))
        CMD_WR_LO, CMD_WR_HI: begin
          if (req.level) begin
            second_num_next = (cmd_t'(req.cmd) == CMD_WR_LO) ?
              {second_num[NUM_W-1:FIELD_W], req.data[FIELD_W-1:0]} :
              {req.data[FIELD_W-1:0], second_num[FIELD_W-1:0]};
            second_line_next = '0;
          end else begin
            first_num_next = (cmd_t'(req.cmd) == CMD_WR_LO) ?
              {first_num[NUM_W-1:FIELD_W], req.data[FIELD_W-1:0]} :
              {req.data[FIELD_W-1:0], first_num[FIELD_W-1:0]};
            first_line_next = '0;
          end
        end
        CMD_READ: begin
          read_byte = cur_line[3] ? req.font_word[7:0] : high_byte;
          if (req.level) begin
            second_line_next = second_line + 1'b1;
          end else begin
            first_line_next = first_line + 1'b1;
          end
        end
        CMD_DUMMY: begin
          read_byte = DUMMY_BYTE;
        end
        default: begin
          read_byte = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_num   <= '0;
      second_num  <= '0;
      first_line  <= '0;
      second_line <= '0;
    end else begin
      first_num   <= first_num_next;
      second_num  <= second_num_next;
      first_line  <= first_line_next;
      second_line <= second_line_next;
    end
  end

  assign first_sym      = first_num_next < SYM_LIMIT;
  assign first_dividend = first_sym ? DIVIDEND_W'(first_num_next)
                                    : DIVIDEND_W'(first_num_next) + KANJI_BIAS;

  kfrp_divmod96 u_first_div (
    .value (first_dividend),
    .quot  (first_quot),
    .rem   (first_rem)
  );

  kfrp_divmod96 u_second_div (
    .value (DIVIDEND_W'(second_num_next)),
    .quot  (second_quot),
    .rem   (second_rem)
  );

  assign first_idx  = IDX_W'(first_quot) * IDX_W'(CHARS_PER_KU) + IDX_W'(first_rem);
  assign second_idx = IDX_W'(second_quot) * IDX_W'(CHARS_PER_KU) + IDX_W'(second_rem);
  assign first_off  = {first_line_next[4], first_line_next[2:0]};
  assign second_off = {second_line_next[4], second_line_next[2:0]};

  always_comb begin
    result.read_data = read_byte;
    result.fetch_addr_first = {first_idx, {WORD_SHIFT{1'b0}}} + ADDR_W'(first_off) +
                              (first_sym ? FIRST_SYM_ADJ : FIRST_KANJI_ADJ);
    result.fetch_addr_second = {second_idx, {WORD_SHIFT{1'b0}}} + ADDR_W'(second_off) +
                               SECOND_ADJ;
  end

  kfrp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (buf_ready),
    .in_data   (result),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.read_data         = rsp_data.read_data;
  assign rsp.fetch_addr_first  = rsp_data.fetch_addr_first;
  assign rsp.fetch_addr_second = rsp_data.fetch_addr_second;

  a_write_rewinds: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == CMD_WR_LO || req.cmd == CMD_WR_HI) && !req.level)
    |=> (first_line == '0))
    else $error("Number write did not clear the first-level line counter.");

  a_read_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_READ && req.level)
    |=> (second_line == LINE_W'($past(second_line) + 1'b1)))
    else $error("Second-level read did not advance the line counter.");

  a_dummy_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_DUMMY)
    |=> ($stable(first_num) && $stable(second_num) &&
         $stable(first_line) && $stable(second_line)))
    else $error("Dummy read changed the port state.");

endmodule

// ===== dv/tb_kanji_font_rom_port_unit.sv =====
`timescale 1ns / 1ps

module tb_kanji_font_rom_port_unit;
  import kfrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 600;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT_RESULT = 150;
  localparam int DRAIN_AT_ITEM = 300;
  localparam int END_WAIT = 20;
  localparam int NUM_DIRECTED = 25;

  typedef struct {
    cmd_t        cmd;
    logic        level;
    logic [7:0]  data;
    logic [15:0] word;
    bit          typed;
    rsp_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kfrp_req_if req_bus();
  kfrp_rsp_if rsp_bus();

  kanji_font_rom_port_unit i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [11:0] char_code [2] = '{12'd0, 12'd0};
  logic [4:0]  glyph_row [2] = '{5'd0, 5'd0};
  logic [7:0]  level1_check [8] = '{
    8'h00, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
  };
  logic [7:0]  level2_check [8] = '{
    8'h01, 8'h02, 8'h0c, 8'h37, 8'hc0, 8'h3b, 8'h2a, 8'h2a
  };

  rsp_t due_responses [$];
  int   errors = 0;
  int   results_seen = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   reads_done [2] = '{0, 0};
  int   writes_done = 0;
  int   dummies_done = 0;
  int   check_bytes = 0;
  bit   no_idle = 1'b0;
  bit   hold_done = 1'b0;

  dir_row_t dir_rows [NUM_DIRECTED] = '{
    '{CMD_DUMMY, 1'b0, 8'h00, 16'h0000, 1'b1, '{8'hFF, 17'h1FA10, 17'h0EAF0}},
    '{CMD_READ,  1'b0, 8'h00, 16'hA55A, 1'b1, '{8'hA5, 17'h1FA11, 17'h0EAF0}},
    '{CMD_READ,  1'b1, 8'h00, 16'h3CC3, 1'b1, '{8'h3C, 17'h1FA11, 17'h0EAF1}},
    '{CMD_DUMMY, 1'b1, 8'hFF, 16'hFFFF, 1'b1, '{8'hFF, 17'h1FA11, 17'h0EAF1}},
    '{CMD_WR_LO, 1'b0, 8'hFF, 16'h0000, 1'b0, '0},
    '{CMD_WR_HI, 1'b0, 8'hFF, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b0, 8'h00, 16'hFFFF, 1'b0, '0},
    '{CMD_WR_LO, 1'b1, 8'hC0, 16'hFFFF, 1'b0, '0},
    '{CMD_WR_HI, 1'b1, 8'h3F, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b1, 8'h00, 16'h0001, 1'b0, '0},
    '{CMD_WR_HI, 1'b0, 8'h02, 16'h0000, 1'b0, '0},
    '{CMD_WR_LO, 1'b0, 8'h40, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b0, 8'hAA, 16'h1234, 1'b0, '0},
    '{CMD_READ,  1'b0, 8'h55, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b0, 8'h00, 16'hFFFF, 1'b0, '0},
    '{CMD_WR_HI, 1'b1, 8'h35, 16'h0000, 1'b0, '0},
    '{CMD_WR_LO, 1'b1, 8'hBE, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b1, 8'h00, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b1, 8'h00, 16'hFFFF, 1'b0, '0},
    '{CMD_READ,  1'b1, 8'h00, 16'h8001, 1'b0, '0},
    '{CMD_WR_HI, 1'b0, 8'h10, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b0, 8'h00, 16'hC33C, 1'b0, '0},
    '{CMD_WR_HI, 1'b0, 8'h0F, 16'h0000, 1'b0, '0},
    '{CMD_WR_LO, 1'b0, 8'h3F, 16'h0000, 1'b0, '0},
    '{CMD_READ,  1'b0, 8'h00, 16'h5AA5, 1'b0, '0}
  };

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // The first level has a symbol area below code 1024 and a kanji area from code 1024 up.
  function automatic void split_code(input logic lvl, output int ku, output int ten,
                                     output int base);
    int n;
    n = char_code[lvl];
    if (lvl) begin
      ku = n / 96;
      ten = n % 96 - 1;
      base = 'hEB00;
    end else if (n < 1024) begin
      ku = n / 96 - 1;
      ten = n % 96 - 1;
      base = 0;
    end else begin
      ku = (n + 512) / 96 - 16;
      ten = (n + 512) % 96 - 1;
      base = 'h2F00;
    end
  endfunction

  function automatic logic [16:0] next_fetch(input logic lvl);
    int ku;
    int ten;
    int base;
    int row;
    int a;
    split_code(lvl, ku, ten, base);
    row = glyph_row[lvl];
    a = base + (ku * 94 + ten) * 16 + row % 8 + (row / 16) * 8;
    return a[16:0];
  endfunction

  function automatic rsp_t font_port_step(input cmd_t cmd, input logic lvl,
                                          input logic [7:0] data,
                                          input logic [15:0] word);
    rsp_t        r;
    int          ku;
    int          ten;
    int          base;
    logic [4:0]  row;
    logic [15:0] w;
    bit          check;
    r.read_data = 8'h00;
    case (cmd)
      CMD_WR_LO: begin
        char_code[lvl][5:0] = data[5:0];
        glyph_row[lvl] = 5'd0;
        writes_done++;
      end
      CMD_WR_HI: begin
        char_code[lvl][11:6] = data[5:0];
        glyph_row[lvl] = 5'd0;
        writes_done++;
      end
      CMD_DUMMY: begin
        r.read_data = 8'hFF;
        dummies_done++;
      end
      default: begin
        row = glyph_row[lvl];
        w = word;
        split_code(lvl, ku, ten, base);
        if (lvl) begin
          check = (ku == 35 && ten == 93 && row < 8);
        end else begin
          check = (base == 0 && ku == 0 && ten == 31 && row < 8);
        end
        if (check) begin
          w[15:8] = lvl ? level2_check[row[2:0]] : level1_check[row[2:0]];
          check_bytes++;
        end
        r.read_data = row[3] ? w[7:0] : w[15:8];
        glyph_row[lvl] = row + 5'd1;
        reads_done[lvl]++;
      end
    endcase
    r.fetch_addr_first = next_fetch(1'b0);
    r.fetch_addr_second = next_fetch(1'b1);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(3, 1);
    end
    if (r < 97) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Codes 128 and 3454 select the check-pattern characters of the two levels.
  function automatic logic [11:0] pick_code(input logic lvl);
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      return lvl ? 12'd3454 : 12'd128;
    end
    if (r < 30) begin
      case ($urandom_range(6))
        0: begin
          return 12'd0;
        end
        1: begin
          return 12'd95;
        end
        2: begin
          return 12'd96;
        end
        3: begin
          return 12'd1023;
        end
        4: begin
          return 12'd1024;
        end
        5: begin
          return 12'd4095;
        end
        default: begin
          return 12'(96 * $urandom_range(42));
        end
      endcase
    end
    return 12'($urandom);
  endfunction

  task automatic send_item(input cmd_t cmd, input logic lvl, input logic [7:0] data,
                           input logic [15:0] word, input bit typed, input rsp_t want);
    rsp_t predicted;
    int   gap;
    predicted = font_port_step(cmd, lvl, data, word);
    if (typed) begin
      predicted = want;
    end
    req_bus.cmd <= cmd;
    req_bus.level <= lvl;
    req_bus.data <= data;
    req_bus.font_word <= word;
    req_bus.valid <= 1'b1;
    do @(posedge clk); while (!req_bus.ready);
    due_responses.push_back(predicted);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_write(input cmd_t cmd, input logic lvl, input logic [11:0] code);
    logic [5:0] field;
    field = (cmd == CMD_WR_HI) ? code[11:6] : code[5:0];
    send_item(cmd, lvl, {2'($urandom), field}, 16'($urandom), 1'b0, '0);
  endtask

  initial begin
    logic        lvl;
    logic [11:0] code;
    cmd_t        first_cmd;
    int          reads;
    bit          drained;
    drained = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.cmd = CMD_DUMMY;
    req_bus.level = 1'b0;
    req_bus.data = 8'h00;
    req_bus.font_word = 16'h0000;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].level, dir_rows[i].data, dir_rows[i].word,
                dir_rows[i].typed, dir_rows[i].want);
    end

    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      if (!drained && items_sent >= DRAIN_AT_ITEM) begin
        req_bus.valid <= 1'b0;
        while (due_responses.size() != 0) @(negedge clk);
        @(negedge clk);
        drained = 1'b1;
      end
      no_idle = (items_sent >= 400 && items_sent < 480);
      if ($urandom_range(9) == 0) begin
        send_item(cmd_t'($urandom_range(3)), 1'($urandom), 8'($urandom), 16'($urandom),
                  1'b0, '0);
      end else begin
        // Set a character number, then read a run of its lines.
        lvl = 1'($urandom);
        code = pick_code(lvl);
        first_cmd = $urandom_range(1) ? CMD_WR_HI : CMD_WR_LO;
        send_write(first_cmd, lvl, code);
        if ($urandom_range(9) != 0) begin
          send_write((first_cmd == CMD_WR_HI) ? CMD_WR_LO : CMD_WR_HI, lvl, code);
        end
        reads = ($urandom_range(3) == 0) ? $urandom_range(70, 32) : $urandom_range(12, 1);
        for (int k = 0; k < reads; k++) begin
          if ($urandom_range(11) == 0) begin
            send_item($urandom_range(1) ? CMD_DUMMY : CMD_READ, 1'($urandom),
                      8'($urandom), 16'($urandom), 1'b0, '0);
          end else begin
            send_item(CMD_READ, lvl, 8'($urandom), 16'($urandom), 1'b0, '0);
          end
        end
      end
    end

    req_bus.valid <= 1'b0;
    while (due_responses.size() != 0) @(negedge clk);
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d first-level and %0d second-level pattern reads, %0d writes,",
             reads_done[0], reads_done[1], writes_done);
    $display("%0d dummy reads and %0d check-pattern bytes; %0d responses compared",
             dummies_done, check_bytes, results_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        stall = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t oldest;
    if (!rst) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_responses.size() == 0) begin
          flag_mismatch("response transaction with none outstanding");
        end else begin
          oldest = due_responses.pop_front();
          results_seen++;
          if (rsp_bus.read_data !== oldest.read_data) begin
            flag_mismatch($sformatf("read_data got %02h want %02h",
                                    rsp_bus.read_data, oldest.read_data));
          end
          if (rsp_bus.fetch_addr_first !== oldest.fetch_addr_first) begin
            flag_mismatch($sformatf("fetch_addr_first got %05h want %05h",
                                    rsp_bus.fetch_addr_first, oldest.fetch_addr_first));
          end
          if (rsp_bus.fetch_addr_second !== oldest.fetch_addr_second) begin
            flag_mismatch($sformatf("fetch_addr_second got %05h want %05h",
                                    rsp_bus.fetch_addr_second, oldest.fetch_addr_second));
          end
        end
      end
    end
  end

endmodule
